### hdl/tlfk_pkg.sv
package tlfk_pkg;

  // Rotation cells: requested count, capped at the length of the arctangent table
  localparam int ROTATION_STAGES = 16;
  localparam int MAX_TABLE       = 24;
  localparam int CELLS           = (ROTATION_STAGES < MAX_TABLE) ? ROTATION_STAGES : MAX_TABLE;

  // Accept-to-output path: two prep stages, the cells, then rounding into the result queue
  localparam int LATENCY    = CELLS + 3;
  localparam int FIFO_DEPTH = 2 ** $clog2(LATENCY + 1);
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int SHIFT_W    = $clog2(MAX_TABLE);

  // Field widths
  localparam int ANG_W  = 16;
  localparam int LEN_W  = 16;
  localparam int POS_W  = 18;
  localparam int WRAP_W = 18;
  localparam int FOLD_W = 14;

  // Datapath widths: x/y in Q24 length units, z in 2^-20 degree
  localparam int XW      = 44;
  localparam int ZW      = 29;
  localparam int Z_FRAC  = 14;
  localparam int GAIN_W  = 25;
  localparam int FRAC_W  = 24;

  // Angle constants in 1/64 degree
  localparam logic signed [WRAP_W-1:0] FULL_TURN     = 18'sd23040;
  localparam logic signed [WRAP_W-1:0] HALF_TURN     = 18'sd11520;
  localparam logic signed [WRAP_W-1:0] QUARTER_TURN  = 18'sd5760;
  localparam logic signed [WRAP_W-1:0] TWO_TURNS     = 18'sd46080;
  localparam logic signed [WRAP_W-1:0] TURN_AND_HALF = 18'sd34560;

  // CORDIC gain compensation in Q24
  localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;

  // atan(2^-i) in degrees, Q20
  typedef logic signed [ZW-1:0] atan_tab_t [MAX_TABLE];
  localparam atan_tab_t ATAN_DEG_Q20 = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
    29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
    29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
    29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
    29'sd917,      29'sd458,      29'sd229,      29'sd115,
    29'sd57,       29'sd29,       29'sd14,       29'sd7
  };

  // Register reset values
  localparam logic [LEN_W-1:0] FIRST_LINK_RESET  = 16'd7680;
  localparam logic [LEN_W-1:0] SECOND_LINK_RESET = 16'd3840;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_LINK  = 1'b0,
    REG_SECOND_LINK = 1'b1
  } cfg_reg_t;

  // One link's rotation state
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } link_t;

  // Word travelling down the cell chain
  typedef struct packed {
    logic  valid;
    link_t base;
    link_t tip;
  } stage_t;

endpackage

### hdl/tlfk_if.sv
interface tlfk_in_if import tlfk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] base_joint_angle;
  logic signed [ANG_W-1:0] arm_joint_angle;

  modport source (output valid, output base_joint_angle, output arm_joint_angle, input ready);
  modport sink   (input valid, input base_joint_angle, input arm_joint_angle, output ready);
endinterface

interface tlfk_out_if import tlfk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] end_x;
  logic signed [POS_W-1:0] end_y;

  modport source (output valid, output end_x, output end_y, input ready);
  modport sink   (input valid, input end_x, input end_y, output ready);
endinterface

### hdl/two_link_forward_kinematics.sv
// Path: an accepted word is registered after wrap/fold, after the start-vector multiply and
// after each rotation cell, then rounded and saturated into the queue, from which it is offered.
// Throughput: one word per cycle; a result queue of FIFO_DEPTH words decouples the output,
// and the input is held only once that many words are in flight or queued.
// Reset (synchronous, rst_n low): pipeline and queue emptied, link lengths to FIRST_LINK_RESET and SECOND_LINK_RESET.
module two_link_forward_kinematics import tlfk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tlfk_in_if.sink              in_chan,
  tlfk_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LEN_W-1:0]     cfg_wdata
);

  logic [LEN_W-1:0] first_len_r;
  logic [LEN_W-1:0] second_len_r;
  logic             in_acc;
  logic             credit_ok;
  stage_t           chain [CELLS+1];

  // Link length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_len_r  <= FIRST_LINK_RESET;
      second_len_r <= SECOND_LINK_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_FIRST_LINK:  first_len_r  <= cfg_wdata;
        REG_SECOND_LINK: second_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_chan.ready = credit_ok;
  assign in_acc        = in_chan.valid & credit_ok;

  tlfk_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .base_angle (in_chan.base_joint_angle),
    .arm_angle  (in_chan.arm_joint_angle),
    .first_len  (first_len_r),
    .second_len (second_len_r),
    .d_out      (chain[0])
  );

  // Rotation cells, one table entry each
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    tlfk_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (SHIFT_W'(g)),
      .atan  (ATAN_DEG_Q20[g]),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  tlfk_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .d_in     (chain[CELLS]),
    .in_ready (credit_ok),
    .out_chan (out_chan)
  );

endmodule

### hdl/tlfk_prep.sv
module tlfk_prep import tlfk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_acc,
  input  logic signed [ANG_W-1:0] base_angle,
  input  logic signed [ANG_W-1:0] arm_angle,
  input  logic        [LEN_W-1:0] first_len,
  input  logic        [LEN_W-1:0] second_len,
  output stage_t                  d_out
);

  typedef struct packed {
    logic                     flip;
    logic signed [FOLD_W-1:0] angle;
  } fold_t;

  localparam int PROD_W = LEN_W + 1 + GAIN_W;

  // Reduce to [-half turn, half turn)
  function automatic logic signed [WRAP_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] r;
    r = a;
    if (r >= TURN_AND_HALF) begin
      r = r - TWO_TURNS;
    end else if (r < -TURN_AND_HALF) begin
      r = r + TWO_TURNS;
    end
    if (r >= HALF_TURN) begin
      r = r - FULL_TURN;
    end else if (r < -HALF_TURN) begin
      r = r + FULL_TURN;
    end
    return r;
  endfunction

  // Fold into the right half plane, flag the sign change
  function automatic fold_t fold_angle(input logic signed [WRAP_W-1:0] a);
    fold_t                    f;
    logic signed [WRAP_W-1:0] r;
    r      = a;
    f.flip = 1'b0;
    if (a > QUARTER_TURN) begin
      r      = a - HALF_TURN;
      f.flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      r      = a + HALF_TURN;
      f.flip = 1'b1;
    end
    f.angle = r[FOLD_W-1:0];
    return f;
  endfunction

  // Start vector: length times gain, sign from the fold
  function automatic logic signed [XW-1:0] start_x(input logic [LEN_W-1:0] len,
                                                   input logic            flip);
    logic signed [LEN_W:0]    l;
    logic signed [GAIN_W-1:0] g;
    logic signed [PROD_W-1:0] p;
    l = $signed({1'b0, len});
    g = flip ? -GAIN_Q24 : GAIN_Q24;
    p = l * g;
    return {{(XW-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic logic signed [ZW-1:0] start_z(input logic signed [FOLD_W-1:0] a);
    return {{(ZW-FOLD_W-Z_FRAC){a[FOLD_W-1]}}, a, {Z_FRAC{1'b0}}};
  endfunction

  logic                     base_sum_dummy;
  logic signed [WRAP_W-1:0] base_ext;
  logic signed [WRAP_W-1:0] tip_sum;
  fold_t                    base_f_nxt;
  fold_t                    tip_f_nxt;
  fold_t                    base_f_r;
  fold_t                    tip_f_r;
  logic                     a_valid_r;
  stage_t                   d_nxt;
  stage_t                   d_r;

  // Stage A: wrap and fold both link angles
  assign base_sum_dummy = 1'b0;
  assign base_ext   = {{(WRAP_W-ANG_W){base_angle[ANG_W-1]}}, base_angle};
  assign tip_sum    = base_ext + {{(WRAP_W-ANG_W){arm_angle[ANG_W-1]}}, arm_angle};
  assign base_f_nxt = fold_angle(wrap_angle(base_ext));
  assign tip_f_nxt  = fold_angle(wrap_angle(tip_sum ^ {WRAP_W{base_sum_dummy}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_acc;
    end
    base_f_r <= base_f_nxt;
    tip_f_r  <= tip_f_nxt;
  end

  // Stage B: scale the start vectors, load the angle accumulators
  always_comb begin
    d_nxt.valid  = a_valid_r;
    d_nxt.base.x = start_x(first_len, base_f_r.flip);
    d_nxt.base.y = '0;
    d_nxt.base.z = start_z(base_f_r.angle);
    d_nxt.tip.x  = start_x(second_len, tip_f_r.flip);
    d_nxt.tip.y  = '0;
    d_nxt.tip.z  = start_z(tip_f_r.angle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
    d_r.base <= d_nxt.base;
    d_r.tip  <= d_nxt.tip;
  end

  assign d_out = d_r;

endmodule

### hdl/tlfk_cell.sv
module tlfk_cell import tlfk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SHIFT_W-1:0]   shift,
  input  logic signed [ZW-1:0] atan,
  input  stage_t               d_in,
  output stage_t               d_out
);

  // One micro-rotation, direction from the sign of the residual angle
  function automatic link_t rotate(input link_t l, input logic [SHIFT_W-1:0] sh,
                                   input logic signed [ZW-1:0] t);
    link_t                r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = l.y >>> sh;
    dy = l.x >>> sh;
    if (!l.z[ZW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - t;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + t;
    end
    return r;
  endfunction

  stage_t d_nxt;
  stage_t d_r;

  always_comb begin
    d_nxt.valid = d_in.valid;
    d_nxt.base  = rotate(d_in.base, shift, atan);
    d_nxt.tip   = rotate(d_in.tip, shift, atan);
  end

  // Advance every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_nxt.valid;
    end
    d_r.base <= d_nxt.base;
    d_r.tip  <= d_nxt.tip;
  end

  assign d_out = d_r;

endmodule

### hdl/tlfk_out.sv
module tlfk_out import tlfk_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_acc,
  input  stage_t        d_in,
  output logic          in_ready,
  tlfk_out_if.source    out_chan
);

  localparam int SW  = XW + 1;
  localparam int QW  = SW - FRAC_W;
  localparam logic signed [SW-1:0] ROUND_BIAS = SW'(1) <<< (FRAC_W - 1);
  localparam logic signed [QW-1:0] Q_MAX = QW'((2 ** (POS_W - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(2 ** (POS_W - 1));

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pos_t;

  // Add the two links, round half up, saturate
  function automatic logic signed [POS_W-1:0] finish(input logic signed [XW-1:0] a,
                                                     input logic signed [XW-1:0] b);
    logic signed [SW-1:0] s;
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] c;
    s = {a[XW-1], a} + {b[XW-1], b} + ROUND_BIAS;
    q = s[SW-1:FRAC_W];
    c = q;
    if (q > Q_MAX) begin
      c = Q_MAX;
    end else if (q < Q_MIN) begin
      c = Q_MIN;
    end
    return c[POS_W-1:0];
  endfunction

  pos_t             mem_r [FIFO_DEPTH];
  pos_t             pos_nxt;
  logic [PTR_W:0]   wr_ptr_r;
  logic [PTR_W:0]   rd_ptr_r;
  logic [PTR_W:0]   occ_r;
  logic [PTR_W:0]   occ_nxt;
  logic             wr_en;
  logic             out_acc;

  assign pos_nxt.x = finish(d_in.base.x, d_in.tip.x);
  assign pos_nxt.y = finish(d_in.base.y, d_in.tip.y);
  assign wr_en     = d_in.valid;

  // Result queue
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r[PTR_W-1:0]] <= pos_nxt;
    end
  end

  assign out_chan.valid = (wr_ptr_r != rd_ptr_r);
  assign out_chan.end_x = mem_r[rd_ptr_r[PTR_W-1:0]].x;
  assign out_chan.end_y = mem_r[rd_ptr_r[PTR_W-1:0]].y;
  assign out_acc        = out_chan.valid & out_chan.ready;

  // Count words in flight and queued; hold the input once the queue could fill
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  assign in_ready = (occ_r < (PTR_W+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      occ_r <= occ_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("occupancy above queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((wr_ptr_r - rd_ptr_r) != (PTR_W+1)'(FIFO_DEPTH)))
    else $error("result written into a full queue");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(LATENCY - 1) wr_en)
    else $error("accepted word did not reach the queue on time");

  a_valid_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (occ_r != '0))
    else $error("result offered with nothing counted in flight");

endmodule

### test/tb_top.sv
module tb_top import tlfk_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits and shape
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_WORDS  = 110;
  localparam int PHASES       = 8;
  localparam int PARK_CYCLES  = 400;
  localparam int BURST_WORDS  = 80;
  localparam int MAX_WAIT     = 18;
  localparam int REPORT_LIMIT = 10;

  // Angle and length constants, 1/64 degree and Q24
  localparam int     TURN_FULL    = 23040;
  localparam int     TURN_HALF    = 11520;
  localparam int     TURN_QUARTER = 5760;
  localparam int     ANGLE_MAX    = 23040;
  localparam longint GAIN_COMP    = 64'sd10188014;
  localparam int     ARC_ENTRIES  = 24;
  localparam int     SWEEP_STEPS  = (ROTATION_STAGES < ARC_ENTRIES) ? ROTATION_STAGES : ARC_ENTRIES;
  localparam int     POS_HIGH     = 131071;
  localparam int     POS_LOW      = -131072;
  localparam int     LEN_MAX      = 65535;
  localparam int     BASE_RESET   = 7680;
  localparam int     TIP_RESET    = 3840;

  // atan(2^-i) in degrees, Q20
  localparam longint ARC_DEG_Q20 [ARC_ENTRIES] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  // Directed angle pairs at the reset lengths
  localparam int DIR_WORDS = 19;
  localparam int DIR_BASE [DIR_WORDS] = '{
    0, 23040, -23040, 23040, 5760, 5761, -5760, -5761, 11520, -11520,
    11519, 0, 0, -1, 1, 17280, -17280, -23040, 12345
  };
  localparam int DIR_ARM [DIR_WORDS] = '{
    0, 23040, -23040, -23040, 0, 0, 0, 0, 0, 0,
    1, 5760, -11520, -1, 1, 17280, -17280, 23040, -6789
  };

  // Directed angle pairs at the longest links, where rounding can saturate
  localparam int SAT_WORDS = 6;
  localparam int SAT_BASE [SAT_WORDS] = '{0, 5760, -11520, 0, -5760, 11520};
  localparam int SAT_ARM  [SAT_WORDS] = '{0, 0, 0, 23040, 0, -11520};

  typedef struct {
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    int unsigned             serial;
  } tip_pos_t;

  // Predicts the arm tip for every accepted word and checks results in order
  class tip_position_board;
    tip_pos_t    tip_due_q [$];
    longint      base_len;
    longint      tip_len;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned errors;

    function new();
      base_len  = BASE_RESET;
      tip_len   = TIP_RESET;
      words_in  = 0;
      words_out = 0;
      errors    = 0;
    endfunction

    function void set_link(cfg_reg_t idx, logic [LEN_W-1:0] value);
      if (idx == REG_FIRST_LINK) base_len = value;
      else tip_len = value;
    endfunction

    // Rotate one link of length len by angle and add its Q24 end point
    function void sweep_link(longint len, int angle, inout longint sx, inout longint sy);
      longint x, y, z, dx, dy;
      int     r;
      bit     flip;
      r = angle % TURN_FULL;
      if (r < 0) r += TURN_FULL;
      if (r >= TURN_HALF) r -= TURN_FULL;
      flip = 1'b0;
      if (r > TURN_QUARTER) begin
        r -= TURN_HALF;
        flip = 1'b1;
      end else if (r < -TURN_QUARTER) begin
        r += TURN_HALF;
        flip = 1'b1;
      end
      x = len * GAIN_COMP;
      if (flip) x = -x;
      y = 0;
      z = longint'(r) * 16384;
      for (int i = 0; i < SWEEP_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ARC_DEG_Q20[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ARC_DEG_Q20[i];
        end
      end
      sx += x;
      sy += y;
    endfunction

    // Round to nearest, ties up, then clamp to the output range
    function logic signed [POS_W-1:0] round_pos(longint acc);
      longint v;
      v = (acc + (64'sd1 <<< 23)) >>> 24;
      if (v > POS_HIGH) v = POS_HIGH;
      if (v < POS_LOW) v = POS_LOW;
      return v[POS_W-1:0];
    endfunction

    function void note_angles(logic signed [ANG_W-1:0] base, logic signed [ANG_W-1:0] arm);
      longint   sx, sy;
      int       b, a;
      tip_pos_t tip;
      b  = base;
      a  = arm;
      sx = 0;
      sy = 0;
      sweep_link(base_len, b, sx, sy);
      sweep_link(tip_len, b + a, sx, sy);
      tip.end_x  = round_pos(sx);
      tip.end_y  = round_pos(sy);
      tip.serial = words_in;
      tip_due_q.push_back(tip);
      words_in++;
    endfunction

    function void check_tip(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
      tip_pos_t tip;
      words_out++;
      if (tip_due_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: end_x %0d end_y %0d", x, y);
        return;
      end
      tip = tip_due_q.pop_front();
      if (x !== tip.end_x || y !== tip.end_y) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("word %0d: end_x exp %0d got %0d, end_y exp %0d got %0d",
                   tip.serial, tip.end_x, x, tip.end_y, y);
      end
    endfunction

    function int pending();
      return tip_due_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LEN_W-1:0]     cfg_wdata;

  tlfk_in_if  in_bus ();
  tlfk_out_if out_bus ();

  tip_position_board board = new();

  int          park_cycles  = 0;
  int          cycle_count  = 0;
  int unsigned stall_cycles = 0;
  int          settings     = 0;

  two_link_forward_kinematics i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus.sink),
    .out_chan  (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        board.note_angles(in_bus.base_joint_angle, in_bus.arm_joint_angle);
      if (in_bus.valid && !in_bus.ready)
        stall_cycles++;
      if (out_bus.valid && out_bus.ready)
        board.check_tip(out_bus.end_x, out_bus.end_y);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, board.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle cycles for one word: none, any, or now and then
  function automatic int draw_wait(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, MAX_WAIT);
    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
  endfunction

  // Angle draw: mostly uniform, with extremes, quadrant edges and small values
  function automatic int draw_angle();
    int pick, v;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      v = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
    end else if (pick == 6) begin
      v = ($urandom_range(0, 1) == 1) ? ANGLE_MAX : -ANGLE_MAX;
    end else if (pick == 7) begin
      v = int'($urandom_range(0, 8)) * TURN_QUARTER - ANGLE_MAX + int'($urandom_range(0, 6)) - 3;
      if (v > ANGLE_MAX) v = ANGLE_MAX;
      if (v < -ANGLE_MAX) v = -ANGLE_MAX;
    end else if (pick == 8) begin
      v = int'($urandom_range(0, 64)) - 32;
    end else begin
      v = 0;
    end
    return v;
  endfunction

  // Offer one word after gap idle cycles and hold it until taken
  task automatic send_word(int base, int arm, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.base_joint_angle <= ANG_W'(base);
    in_bus.arm_joint_angle  <= ANG_W'(arm);
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle_block();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_link(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= LEN_W'(value);
    board.set_link(idx, LEN_W'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, with one long hold-off on request
  initial begin : result_sink
    int stall;
    int mode;
    bit parked;
    mode          = 1;
    parked        = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) mode = $urandom_range(0, 2);
      stall = draw_wait(mode);
      if (park_cycles > 0 && !parked) begin
        stall  = park_cycles;
        parked = 1'b1;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin : stimulus
    int send_mode;
    int len_a, len_b;
    send_mode = 1;
    rst_n                   = 1'b0;
    in_bus.valid            = 1'b0;
    in_bus.base_joint_angle = '0;
    in_bus.arm_joint_angle  = '0;
    cfg_we                  = 1'b0;
    cfg_idx                 = REG_FIRST_LINK;
    cfg_wdata               = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset lengths
    settings++;
    for (int n = 0; n < DIR_WORDS; n++)
      send_word(DIR_BASE[n], DIR_ARM[n], draw_wait(send_mode));

    // Longest links: rounding may clip at the output range
    settle_block();
    write_link(REG_FIRST_LINK, LEN_MAX);
    write_link(REG_SECOND_LINK, LEN_MAX);
    settings++;
    for (int n = 0; n < SAT_WORDS; n++)
      send_word(SAT_BASE[n], SAT_ARM[n], draw_wait(send_mode));

    // Random phases, one link setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin len_a = BASE_RESET; len_b = TIP_RESET; end
        1: begin len_a = LEN_MAX;    len_b = LEN_MAX;   end
        2: begin len_a = 0;          len_b = 0;         end
        3: begin len_a = LEN_MAX;    len_b = 0;         end
        4: begin len_a = 0;          len_b = LEN_MAX;   end
        5: begin len_a = 1;          len_b = $urandom_range(0, 255); end
        default: begin
          len_a = $urandom_range(0, LEN_MAX);
          len_b = $urandom_range(0, LEN_MAX);
        end
      endcase
      settle_block();
      write_link(REG_FIRST_LINK, len_a);
      write_link(REG_SECOND_LINK, len_b);
      settings++;
      send_mode = $urandom_range(0, 2);

      // Hold the output off while words keep coming, so the input backs up
      if (p == 1) begin
        park_cycles = PARK_CYCLES;
        repeat (BURST_WORDS) send_word(draw_angle(), draw_angle(), 0);
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Pause the sender until the block has drained
        if (p == 4 && n == PHASE_WORDS / 2) settle_block();
        if ($urandom_range(0, 39) == 0) send_mode = $urandom_range(0, 2);
        send_word(draw_angle(), draw_angle(), draw_wait(send_mode));
      end
    end

    // Drain, then allow the pipeline time to show any stray word
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d angle pairs over %0d link settings, lengths 0 to %0d",
             board.words_in, settings, LEN_MAX);
    $display("%0d results checked, %0d cycles with the input held back, %0d errors",
             board.words_out, stall_cycles, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hdl/tlfk_pkg.sv
hdl/tlfk_if.sv
hdl/tlfk_prep.sv
hdl/tlfk_cell.sv
hdl/tlfk_out.sv
hdl/two_link_forward_kinematics.sv
test/tb_top.sv
